// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; the using scope provides clk and rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mnrt_pkg.sv =====
// ---------------------------------------------------------------------------
// mnrt_pkg
// Types, widths and codes shared by the neighbor route table modules.
// ---------------------------------------------------------------------------
package mnrt_pkg;

    localparam int MAX_NODES_DEF = 16;

    localparam int ID_W       = 16;
    localparam int MAC_W      = 48;
    localparam int RSSI_W     = 8;
    localparam int HOPS_W     = 8;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    localparam logic signed [RSSI_W-1:0] RSSI_FLOOR = -8'sd128;
    localparam logic [HOPS_W-1:0]        HOPS_CEIL  = 8'd255;

    localparam logic [ID_W-1:0]   OWN_ID_RST  = 16'd1;
    localparam logic [TIME_W-1:0] TIMEOUT_RST = 32'd300000;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_NODE_ID = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_TMO   = 1'b1;

    typedef enum logic [1:0] {
        CMD_UPDATE = 2'd0,
        CMD_PRUNE  = 2'd1,
        CMD_ROUTE  = 2'd2,
        CMD_FIND   = 2'd3
    } cmd_e;

    typedef struct packed {
        logic [1:0]               command;
        logic [ID_W-1:0]          node_id;
        logic [MAC_W-1:0]         mac_address;
        logic signed [RSSI_W-1:0] link_rssi;
        logic [HOPS_W-1:0]        hops_to_gateway;
        logic                     sender_is_gateway;
        logic [TIME_W-1:0]        now_ms;
    } req_t;

    typedef struct packed {
        logic                     found;
        logic [ID_W-1:0]          hit_node_id;
        logic [MAC_W-1:0]         hit_mac;
        logic signed [RSSI_W-1:0] hit_rssi;
        logic [HOPS_W-1:0]        hit_hops;
        logic                     hit_is_gateway;
        logic [HOPS_W-1:0]        advertised_hops;
        logic                     added;
        logic                     dropped;
        logic [COUNT_W-1:0]       removed_count;
        logic [COUNT_W-1:0]       entry_count;
    } rsp_t;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [MAC_W-1:0]         mac;
        logic signed [RSSI_W-1:0] rssi;
        logic [HOPS_W-1:0]        hops;
        logic                     gw;
        logic [TIME_W-1:0]        last_seen;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic scan;
        logic write;
        logic fetch;
        logic finish;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        cmd_e op;
        logic scan_done;
        logic hit_valid;
        logic out_free;
    } dp_status_t;

endpackage

// ===== hw/rtl/mnrt_req_if.sv =====
// ---------------------------------------------------------------------------
// mnrt_req_if
// Request channel: valid/ready handshake with the table command payload.
// ---------------------------------------------------------------------------
interface mnrt_req_if
    import mnrt_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic [1:0]               command;
    logic [ID_W-1:0]          node_id;
    logic [MAC_W-1:0]         mac_address;
    logic signed [RSSI_W-1:0] link_rssi;
    logic [HOPS_W-1:0]        hops_to_gateway;
    logic                     sender_is_gateway;
    logic [TIME_W-1:0]        now_ms;

    modport source (
        output valid, command, node_id, mac_address, link_rssi,
               hops_to_gateway, sender_is_gateway, now_ms,
        input  ready
    );

    modport sink (
        input  valid, command, node_id, mac_address, link_rssi,
               hops_to_gateway, sender_is_gateway, now_ms,
        output ready
    );

endinterface

// ===== hw/rtl/mnrt_rsp_if.sv =====
// ---------------------------------------------------------------------------
// mnrt_rsp_if
// Response channel: valid/ready handshake with the table result payload.
// ---------------------------------------------------------------------------
interface mnrt_rsp_if
    import mnrt_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic                     found;
    logic [ID_W-1:0]          hit_node_id;
    logic [MAC_W-1:0]         hit_mac;
    logic signed [RSSI_W-1:0] hit_rssi;
    logic [HOPS_W-1:0]        hit_hops;
    logic                     hit_is_gateway;
    logic [HOPS_W-1:0]        advertised_hops;
    logic                     added;
    logic                     dropped;
    logic [COUNT_W-1:0]       removed_count;
    logic [COUNT_W-1:0]       entry_count;

    modport source (
        output valid, found, hit_node_id, hit_mac, hit_rssi, hit_hops,
               hit_is_gateway, advertised_hops, added, dropped,
               removed_count, entry_count,
        input  ready
    );

    modport sink (
        input  valid, found, hit_node_id, hit_mac, hit_rssi, hit_hops,
               hit_is_gateway, advertised_hops, added, dropped,
               removed_count, entry_count,
        output ready
    );

endinterface

// ===== hw/rtl/mnrt_ctrl.sv =====
// ---------------------------------------------------------------------------
// mnrt_ctrl
// Sequencer: accept, scan table, write or fetch if needed, then hand off the result.
// ---------------------------------------------------------------------------
module mnrt_ctrl
    import mnrt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FETCH,
        ST_FINISH
    } state_t;

    state_t state_reg;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.load   = (state_reg == ST_IDLE) && in_valid;
        cmd.scan   = (state_reg == ST_SCAN);
        cmd.write  = (state_reg == ST_WRITE);
        cmd.fetch  = (state_reg == ST_FETCH);
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        state_reg <= ST_SCAN;
                end
                ST_SCAN:
                begin
                    if (status.scan_done)
                    begin
                        case (status.op) inside
                            CMD_UPDATE:
                                state_reg <= ST_WRITE;
                            CMD_ROUTE, CMD_FIND:
                                state_reg <= status.hit_valid ? ST_FETCH : ST_FINISH;
                            default:
                                state_reg <= ST_FINISH;
                        endcase
                    end
                end
                ST_WRITE:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FETCH:
                begin
                    state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (status.out_free)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/mnrt_dp.sv =====
// ---------------------------------------------------------------------------
// mnrt_dp
// Table memory, scan pipeline, selection trackers and result register.
// ---------------------------------------------------------------------------
module mnrt_dp
    import mnrt_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ID_W-1:0]   own_node_id,
    input  logic [TIME_W-1:0] route_timeout_ms,
    input  req_t              item,
    input  dp_cmd_t           cmd,
    output dp_status_t        status,
    output logic              out_valid,
    input  logic              out_ready,
    output rsp_t              out_data
);

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1);

    // table memory, one write and one read port, registered read
    entry_t mem [MAX_NODES];

    req_t                     item_reg;
    entry_t                   rd_data_reg;
    logic [CW-1:0]            fill_reg;
    logic [CW-1:0]            rd_cnt_reg;
    logic                     pend_valid_reg;
    logic [IW-1:0]            pend_idx_reg;
    logic [CW-1:0]            keep_cnt_reg;
    logic [CW-1:0]            removed_cnt_reg;
    logic                     match_found_reg;
    logic [IW-1:0]            match_idx_reg;
    logic                     gw_found_reg;
    logic [IW-1:0]            gw_idx_reg;
    logic signed [RSSI_W-1:0] gw_rssi_reg;
    logic                     hop_found_reg;
    logic [IW-1:0]            hop_idx_reg;
    logic [HOPS_W-1:0]        hop_val_reg;
    logic                     added_reg;
    logic                     dropped_reg;
    logic                     out_valid_reg;
    rsp_t                     out_data_reg;

    cmd_e          op;
    logic          lookup;
    logic          scan_more;
    logic          issue;
    logic          proc;
    logic          lookup_hit;
    logic          gw_better;
    logic          hop_better;
    logic [TIME_W-1:0] age;
    logic          expired;
    logic          keep_move;
    logic          own_hit;
    logic          can_add;
    logic          upd_wr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    entry_t        wr_data;
    entry_t        new_entry;
    logic [IW-1:0] sel_idx;
    logic          hit_valid;
    logic [CW-1:0] fill_after;
    logic [31:0]   fill_ext;
    logic [31:0]   removed_ext;
    logic          show_hit;
    rsp_t          rsp_next;

    assign op     = cmd_e'(item_reg.command);
    assign lookup = (op == CMD_UPDATE) || (op == CMD_FIND);

    // scan pipeline: address issued, entry examined in the next cycle
    assign scan_more = (rd_cnt_reg < fill_reg) && !(lookup && match_found_reg);
    assign issue     = cmd.scan && scan_more;
    assign proc      = cmd.scan && pend_valid_reg;

    assign lookup_hit = proc && lookup && !match_found_reg
                        && (rd_data_reg.id == item_reg.node_id);
    assign gw_better  = proc && (op == CMD_ROUTE) && rd_data_reg.gw
                        && (rd_data_reg.rssi > gw_rssi_reg);
    assign hop_better = proc && (op == CMD_ROUTE) && (rd_data_reg.hops < hop_val_reg);

    assign age       = item_reg.now_ms - rd_data_reg.last_seen;
    assign expired   = age > route_timeout_ms;
    assign keep_move = proc && (op == CMD_PRUNE) && !expired
                       && (32'(keep_cnt_reg) != 32'(pend_idx_reg));

    assign own_hit = (item_reg.node_id == own_node_id);
    assign can_add = (fill_reg < CW'(MAX_NODES));
    assign upd_wr  = cmd.write && !own_hit && (match_found_reg || can_add);

    assign new_entry = '{id:        item_reg.node_id,
                         mac:       item_reg.mac_address,
                         rssi:      item_reg.link_rssi,
                         hops:      item_reg.hops_to_gateway,
                         gw:        item_reg.sender_is_gateway,
                         last_seen: item_reg.now_ms};

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = keep_cnt_reg[IW-1:0];
        wr_data = rd_data_reg;
        if (keep_move)
        begin
            wr_en = 1'b1;
        end
        else if (upd_wr)
        begin
            wr_en   = 1'b1;
            wr_addr = match_found_reg ? match_idx_reg : fill_reg[IW-1:0];
            wr_data = new_entry;
        end
    end

    assign sel_idx   = (op == CMD_FIND) ? match_idx_reg
                     : (gw_found_reg ? gw_idx_reg : hop_idx_reg);
    assign hit_valid = (op == CMD_FIND) ? match_found_reg
                     : ((op == CMD_ROUTE) && (gw_found_reg || hop_found_reg));

    assign status = '{op:        op,
                      scan_done: !pend_valid_reg && !scan_more,
                      hit_valid: hit_valid,
                      out_free:  !out_valid_reg || out_ready};

    // counts are reported modulo 2^COUNT_W
    assign fill_after  = (op == CMD_PRUNE) ? keep_cnt_reg : fill_reg;
    assign fill_ext    = 32'(fill_after);
    assign removed_ext = 32'(removed_cnt_reg);
    assign show_hit    = hit_valid;

    always_comb
    begin
        rsp_next               = '0;
        rsp_next.found         = show_hit;
        rsp_next.added         = added_reg;
        rsp_next.dropped       = dropped_reg;
        rsp_next.removed_count = removed_ext[COUNT_W-1:0];
        rsp_next.entry_count   = fill_ext[COUNT_W-1:0];
        if (show_hit)
        begin
            rsp_next.hit_node_id    = rd_data_reg.id;
            rsp_next.hit_mac        = rd_data_reg.mac;
            rsp_next.hit_rssi       = rd_data_reg.rssi;
            rsp_next.hit_hops       = rd_data_reg.hops;
            rsp_next.hit_is_gateway = rd_data_reg.gw;
            if (op == CMD_ROUTE)
                rsp_next.advertised_hops = rd_data_reg.hops + 8'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            rd_cnt_reg      <= '0;
            pend_valid_reg  <= 1'b0;
            keep_cnt_reg    <= '0;
            removed_cnt_reg <= '0;
            match_found_reg <= 1'b0;
            gw_found_reg    <= 1'b0;
            hop_found_reg   <= 1'b0;
            added_reg       <= 1'b0;
            dropped_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                rd_cnt_reg      <= '0;
                pend_valid_reg  <= 1'b0;
                keep_cnt_reg    <= '0;
                removed_cnt_reg <= '0;
                match_found_reg <= 1'b0;
                gw_found_reg    <= 1'b0;
                hop_found_reg   <= 1'b0;
                added_reg       <= 1'b0;
                dropped_reg     <= 1'b0;
            end
            if (cmd.scan)
                pend_valid_reg <= issue;
            if (issue)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            if (lookup_hit)
                match_found_reg <= 1'b1;
            if (gw_better)
                gw_found_reg <= 1'b1;
            if (hop_better)
                hop_found_reg <= 1'b1;
            if (proc && (op == CMD_PRUNE))
            begin
                if (expired)
                    removed_cnt_reg <= removed_cnt_reg + CW'(1);
                else
                    keep_cnt_reg <= keep_cnt_reg + CW'(1);
            end
            if (cmd.write)
            begin
                if (own_hit || (!match_found_reg && !can_add))
                    dropped_reg <= 1'b1;
                else if (!match_found_reg)
                begin
                    added_reg <= 1'b1;
                    fill_reg  <= fill_reg + CW'(1);
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
                if (op == CMD_PRUNE)
                    fill_reg <= keep_cnt_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and table storage
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg    <= item;
            gw_rssi_reg <= RSSI_FLOOR;
            hop_val_reg <= HOPS_CEIL;
        end
        if (issue)
        begin
            rd_data_reg  <= mem[rd_cnt_reg[IW-1:0]];
            pend_idx_reg <= rd_cnt_reg[IW-1:0];
        end
        else if (cmd.fetch)
        begin
            rd_data_reg <= mem[sel_idx];
        end
        if (lookup_hit)
            match_idx_reg <= pend_idx_reg;
        if (gw_better)
        begin
            gw_idx_reg  <= pend_idx_reg;
            gw_rssi_reg <= rd_data_reg.rssi;
        end
        if (hop_better)
        begin
            hop_idx_reg <= pend_idx_reg;
            hop_val_reg <= rd_data_reg.hops;
        end
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (cmd.finish)
            out_data_reg <= rsp_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== hw/rtl/mesh_neighbor_route_table.sv =====
// ---------------------------------------------------------------------------
// mesh_neighbor_route_table
// Neighbor table with aging, lookup and gateway route selection.
// ---------------------------------------------------------------------------
// Keeps up to MAX_NODES neighbors in insertion order in a single-port-read,
// single-port-write table memory and serves one request at a time, with one
// response per request. An update refreshes a known id in place or appends
// a new one (own id or full table: dropped). A prune drops entries whose
// wrapped age (now_ms - last_seen) exceeds route_timeout_ms and compacts the
// survivors in order, writing each moved entry back as it is scanned. A
// route query picks the gateway with strictly best RSSI above -128, else the
// entry with fewest hops below 255, earliest on ties. A find returns the
// entry with a matching id. A request is accepted, then the table is scanned
// through the memory read port at one entry per cycle; lookups stop scanning
// at the first match. Then comes a write or fetch step (none for a prune, or
// for a query or find that misses) and a result step. The next request is
// accepted while a response still waits in the output register.
// Configuration must be written only while idle; the block itself does not
// enforce this.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mesh_neighbor_route_table
    import mnrt_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    mnrt_req_if.sink              req,
    mnrt_rsp_if.source            rsp
);

    // configuration registers
    logic [ID_W-1:0]   own_node_id_reg;
    logic [TIME_W-1:0] route_timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_node_id_reg   <= OWN_ID_RST;
            route_timeout_reg <= TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_OWN_NODE_ID: own_node_id_reg   <= cfg_wdata[ID_W-1:0];
                CFG_ROUTE_TMO:   route_timeout_reg <= cfg_wdata[TIME_W-1:0];
                default:         ;
            endcase
        end
    end

    // request payload gathered into one word for the datapath
    req_t       item;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic       in_ready;
    logic       out_valid;
    rsp_t       out_data;

    assign item = '{command:           req.command,
                    node_id:           req.node_id,
                    mac_address:       req.mac_address,
                    link_rssi:         req.link_rssi,
                    hops_to_gateway:   req.hops_to_gateway,
                    sender_is_gateway: req.sender_is_gateway,
                    now_ms:            req.now_ms};

    assign req.ready = in_ready;

    // sequencer: owns the request handshake and steps the datapath
    mnrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .status   (status)
    );

    // table memory, scan, selection and the response register
    mnrt_dp #(
        .MAX_NODES (MAX_NODES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .own_node_id      (own_node_id_reg),
        .route_timeout_ms (route_timeout_reg),
        .item             (item),
        .cmd              (cmd),
        .status           (status),
        .out_valid        (out_valid),
        .out_ready        (rsp.ready),
        .out_data         (out_data)
    );

    assign rsp.valid           = out_valid;
    assign rsp.found           = out_data.found;
    assign rsp.hit_node_id     = out_data.hit_node_id;
    assign rsp.hit_mac         = out_data.hit_mac;
    assign rsp.hit_rssi        = out_data.hit_rssi;
    assign rsp.hit_hops        = out_data.hit_hops;
    assign rsp.hit_is_gateway  = out_data.hit_is_gateway;
    assign rsp.advertised_hops = out_data.advertised_hops;
    assign rsp.added           = out_data.added;
    assign rsp.dropped         = out_data.dropped;
    assign rsp.removed_count   = out_data.removed_count;
    assign rsp.entry_count     = out_data.entry_count;

    // at most one datapath step per cycle
    `ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd), "datapath commands overlap")
    // a result is never loaded over one still waiting
    `ASSERT_IMPLIES(a_no_overwrite, cmd.finish, !rsp.valid || rsp.ready, "response overwritten")
    // fetch only when the scan selected an entry
    `ASSERT_IMPLIES(a_fetch_hit, cmd.fetch, status.hit_valid, "fetch without a selected entry")
    // a request is in flight after accept, so no back-to-back accept
    `ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "accepted while busy")

endmodule
